[sv/sjgl_pkg.sv]
`default_nettype none

package sjgl_pkg;

    // Width of the pixel cursor; the cursor wraps modulo 2**CURSOR_BITS.
    localparam int CURSOR_BITS = 12;
    localparam int DX_W        = 13;
    localparam int OFF_W       = 20;
    localparam int KT_W        = 10;
    localparam int Q_AW        = 2;
    localparam int Q_DEPTH     = 1 << Q_AW;
    localparam int Q_CW        = Q_AW + 1;

    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_SJIS   = 2'd1;
    localparam logic [1:0] MODE_EUC    = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    typedef logic [CURSOR_BITS-1:0] t_cursor;
    typedef logic [DX_W-1:0]        t_dx;
    typedef logic [OFF_W-1:0]       t_off;

    // One decoded command handed from the front part to the back part.
    typedef struct packed {
        logic                   pair;
        logic                   sel;
        t_cursor                cursor;
        logic [7:0]             code;
        logic signed [KT_W-1:0] k;
        logic signed [KT_W-1:0] t;
    } t_cmd;

    function automatic t_dx cursor_to_dx(input t_cursor c);
        logic [CURSOR_BITS+DX_W-1:0] tmp;
        tmp = {{DX_W{1'b0}}, c};
        return tmp[DX_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/sjgl_front.sv]
`default_nettype none

module sjgl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_wdata,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_code_byte,
    input  wire logic          i_new_string,
    input  wire logic [11:0]   i_start_x,
    output logic               o_q_push,
    output sjgl_pkg::t_cmd     o_q_cmd
);
    import sjgl_pkg::*;

    logic [1:0] r_mode;
    logic [7:0] r_lead;
    t_cursor    r_cursor;

    logic [7:0] n_lead;
    t_cursor    n_cursor;
    t_cursor    cur_eff;
    logic [CURSOR_BITS+11:0] sx_ext;
    logic       lead_hit;
    logic signed [KT_W-1:0] lbs, sbs, k, t;

    assign sx_ext  = {{CURSOR_BITS{1'b0}}, i_start_x};
    assign cur_eff = i_new_string ? sx_ext[CURSOR_BITS-1:0] : r_cursor;
    assign lbs     = signed'({2'b00, r_lead});
    assign sbs     = signed'({2'b00, i_code_byte});

    always_comb begin
        if (r_mode == MODE_SJIS) begin
            lead_hit = (i_code_byte >= 8'h81 && i_code_byte <= 8'h9f) ||
                       (i_code_byte >= 8'he0 && i_code_byte <= 8'hfc);
        end else begin
            lead_hit = i_code_byte >= 8'h81 && i_code_byte <= 8'hfe;
        end
    end

    // Row and cell of a double-byte pair, signed so that malformed pairs
    // carry through as they decode.
    always_comb begin
        if (r_mode == MODE_SJIS) begin
            if (r_lead >= 8'h81 && r_lead <= 8'h9f) begin
                k = (lbs - 10'sd129) * 10'sd2;
            end else begin
                k = (lbs - 10'sd224) * 10'sd2 + 10'sd62;
            end
            if (i_code_byte >= 8'h40 && i_code_byte <= 8'h7e) begin
                t = sbs - 10'sd64;
            end else if (i_code_byte >= 8'h80 && i_code_byte <= 8'h9e) begin
                t = sbs - 10'sd65;
            end else begin
                t = sbs - 10'sd159;
                k = k + 10'sd1;
            end
        end else begin
            k = lbs - 10'sd161;
            t = sbs - 10'sd161;
        end
    end

    always_comb begin
        n_lead          = r_lead;
        n_cursor        = cur_eff;
        o_q_push        = 1'b0;
        o_q_cmd.pair    = 1'b0;
        o_q_cmd.sel     = 1'b1;
        o_q_cmd.cursor  = cur_eff;
        o_q_cmd.code    = i_code_byte;
        o_q_cmd.k       = k;
        o_q_cmd.t       = t;
        if (i_accept && i_code_byte != 8'h00 && r_mode != MODE_OFF) begin
            n_cursor = cur_eff + t_cursor'(8);
            if (r_mode == MODE_SINGLE) begin
                o_q_push    = 1'b1;
                o_q_cmd.sel = 1'b0;
            end else if (r_lead == 8'h00) begin
                if (lead_hit) begin
                    n_lead = i_code_byte;
                end else begin
                    o_q_push = 1'b1;
                end
            end else begin
                o_q_push     = 1'b1;
                o_q_cmd.pair = 1'b1;
                n_lead       = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SINGLE;
            r_lead   <= 8'h00;
            r_cursor <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_lead   <= n_lead;
                r_cursor <= n_cursor;
            end
        end
    end

endmodule

`default_nettype wire

[sv/sjgl_queue.sv]
`default_nettype none

module sjgl_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sjgl_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output sjgl_pkg::t_cmd      o_cmd
);
    import sjgl_pkg::*;

    t_cmd             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0]  r_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == Q_CW'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/sjgl_back.sv]
`default_nettype none

module sjgl_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_empty,
    input  wire sjgl_pkg::t_cmd i_q_cmd,
    output logic                o_q_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [12:0]         o_draw_x,
    output logic                o_font_select,
    output logic [19:0]         o_font_offset,
    output logic                o_last_result
);
    import sjgl_pkg::*;

    logic r_valid, r_phase, r_sel, r_last;
    t_dx  r_dx;
    t_off r_off;

    logic load;
    logic signed [OFF_W-1:0] idx, base;
    t_off n_off;
    t_dx  n_dx;
    logic n_last;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load && (!i_q_cmd.pair || r_phase);

    assign idx  = OFF_W'(i_q_cmd.k) * 20'sd94 + OFF_W'(i_q_cmd.t);
    assign base = 20'sd4096 + (idx <<< 5);

    always_comb begin
        n_dx   = cursor_to_dx(i_q_cmd.cursor);
        n_off  = {8'h00, i_q_cmd.code, 4'h0};
        n_last = 1'b1;
        if (i_q_cmd.pair) begin
            if (!r_phase) begin
                n_dx   = n_dx - t_dx'(8);
                n_off  = base;
                n_last = 1'b0;
            end else begin
                n_off = base + 20'sd16;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dx   <= n_dx;
            r_off  <= n_off;
            r_sel  <= i_q_cmd.sel;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= i_q_cmd.pair && !r_phase;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_valid;
    assign o_draw_x      = r_dx;
    assign o_font_select = r_sel;
    assign o_font_offset = r_off;
    assign o_last_result = r_last;

    // While a left half is shown, the pair it belongs to is still queued.
    a_left_holds_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |-> r_phase && !i_q_empty && i_q_cmd.pair)
        else $error("left half shown without its pair at the queue head");

    a_phase_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> !i_q_empty)
        else $error("second half pending with an empty queue");

    a_pair_no_pop_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_q_cmd.pair && !r_phase |-> !o_q_pop ##1 (r_valid && !r_last))
        else $error("pair dequeued before its right half");

endmodule

`default_nettype wire

[sv/sjis_eucjp_glyph_locator.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ---------------------------------------------
// input     in         i_push / o_full        i_code_byte, i_new_string, i_start_x
// result    out        o_empty / i_pop        o_draw_x, o_font_select, o_font_offset,
//                                             o_last_result
// config    in         i_cfg_we               i_cfg_wdata (lang_mode)
//
// A byte is taken in every cycle while the four-entry command queue has room;
// the front part updates the lead byte and cursor in the cycle it takes a beat.
// The back part puts out one result beat per cycle while the queue is not empty and
// the result side pops; a double-byte pair gives a left and a right half beat, a single
// glyph one beat; the result register sets that rate. A queued command reaches the
// outputs through the result register. Reset (synchronous, active low) clears the
// mode, lead byte, cursor, queue and result valid flag. Either side may stall freely:
// the queue and the result register keep the two apart.

module sjis_eucjp_glyph_locator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_code_byte,
    input  wire logic        i_new_string,
    input  wire logic [11:0] i_start_x,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [12:0]      o_draw_x,
    output logic             o_font_select,
    output logic [19:0]      o_font_offset,
    output logic             o_last_result
);
    import sjgl_pkg::*;

    logic accept;
    logic q_push, q_full, q_pop, q_empty;
    t_cmd front_cmd, head_cmd;

    // A beat is accepted whenever the queue has room, even for a byte that
    // ends up producing no command.
    assign accept = i_push && !q_full;
    assign o_full = q_full;

    sjgl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_code_byte  (i_code_byte),
        .i_new_string (i_new_string),
        .i_start_x    (i_start_x),
        .o_q_push     (q_push),
        .o_q_cmd      (front_cmd)
    );

    sjgl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    sjgl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_cmd       (head_cmd),
        .o_q_pop       (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_draw_x      (o_draw_x),
        .o_font_select (o_font_select),
        .o_font_offset (o_font_offset),
        .o_last_result (o_last_result)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

// Testbench for the glyph locator. A predictor in this module follows every
// accepted input beat, keeps its own copy of the mode, the pending lead byte
// and the cursor, and queues the glyph beats that the block must put out. A
// checking process compares every accepted result beat, field by field,
// against the oldest queued glyph.
//
// The run is a series of test tasks called from one initial block. They all
// send through send_byte, which drives one input beat and waits until the
// block takes it. The result side is driven by its own process, which stalls
// in short random bursts and, on request, for one long stretch.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sjgl_pkg::*;

    // Cycles to let pass after the last expected beat before a mode write or
    // the end of the run.
    localparam int SETTLE_CYCLES = 8;
    // Cycles to wait for outstanding beats before giving up on them.
    localparam int IDLE_LIMIT    = 5000;
    // Number of mismatches that are reported in full.
    localparam int REPORT_LIMIT  = 10;

    // One expected result beat, at the widths of the result ports.
    typedef struct packed {
        t_dx  draw_x;
        logic font_select;
        t_off font_offset;
        logic last_result;
    } t_glyph;

    // Block inputs, all at known values from time zero.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_wdata  = MODE_SINGLE;
    logic        i_push       = 1'b0;
    logic [7:0]  i_code_byte  = 8'h00;
    logic        i_new_string = 1'b0;
    logic [11:0] i_start_x    = 12'h000;
    logic        i_pop        = 1'b0;

    wire logic        o_full;
    wire logic        o_empty;
    wire logic [12:0] o_draw_x;
    wire logic        o_font_select;
    wire logic [19:0] o_font_offset;
    wire logic        o_last_result;

    // Predictor state. It mirrors the block after reset.
    logic [1:0] lang_mode_q = MODE_SINGLE;
    logic [7:0] lead_q      = 8'h00;
    t_cursor    cursor_q    = '0;

    // Glyph beats predicted but not yet seen on the result side.
    t_glyph glyph_q [$];

    int fail_count = 0;

    // Knobs for the two sides. The result side counts its long hold-off
    // down by itself once a test task loads it.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_left  = 0;
    int rx_gap     = 0;

    sjis_eucjp_glyph_locator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_code_byte   (i_code_byte),
        .i_new_string  (i_new_string),
        .i_start_x     (i_start_x),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_draw_x      (o_draw_x),
        .o_font_select (o_font_select),
        .o_font_offset (o_font_offset),
        .o_last_result (o_last_result)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queues one glyph beat. The column and the offset are worked out as
    // plain integers and cut to the port widths here, so that a negative
    // value ends up in two's complement just as the block shows it.
    function automatic void queue_glyph(input int x, input logic sel, input int off,
                                        input logic last);
        logic [31:0] xv;
        logic [31:0] ov;
        t_glyph      g;
        xv = x;
        ov = off;
        g.draw_x      = xv[DX_W-1:0];
        g.font_select = sel;
        g.font_offset = ov[OFF_W-1:0];
        g.last_result = last;
        glyph_q.push_back(g);
    endfunction

    // Lead byte ranges depend on the mode in force when the byte arrives.
    function automatic logic is_lead_byte(input logic [7:0] b);
        if (lang_mode_q == MODE_SJIS)
            return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
        return b >= 8'h81 && b <= 8'hfe;
    endfunction

    // Follows one accepted input beat.
    function automatic void predict_byte(input logic [7:0] b, input logic ns,
                                         input logic [11:0] sx);
        int cur;
        int lb;
        int sb;
        int k;
        int t;
        int base;
        // A new string loads the cursor even when the byte itself is dropped,
        // and it leaves a pending lead byte alone.
        if (ns)
            cursor_q = sx[CURSOR_BITS-1:0];
        // Zero bytes and the off mode change nothing else.
        if (b != 8'h00 && lang_mode_q != MODE_OFF) begin
            cur = int'(cursor_q);
            if (lang_mode_q == MODE_SINGLE) begin
                // The single-byte mode ignores, and keeps, a pending lead.
                queue_glyph(cur, 1'b0, int'(b) * 16, 1'b1);
            end else if (lead_q == 8'h00) begin
                if (is_lead_byte(b))
                    lead_q = b;
                else
                    queue_glyph(cur, 1'b1, int'(b) * 16, 1'b1);
            end else begin
                // Trail byte. A lead that was stored under the other
                // double-byte mode goes through the formulas of the current
                // one, and nothing keeps row or cell from going negative.
                lb = int'(lead_q);
                sb = int'(b);
                if (lang_mode_q == MODE_SJIS) begin
                    if (lb >= 'h81 && lb <= 'h9f)
                        k = (lb - 'h81) * 2;
                    else
                        k = (lb - 'he0) * 2 + 62;
                    if (sb >= 'h40 && sb <= 'h7e) begin
                        t = sb - 'h40;
                    end else if (sb >= 'h80 && sb <= 'h9e) begin
                        t = sb - 'h80 + 63;
                    end else begin
                        // Upper trail range: the second row of the pair.
                        t = sb - 'h9f;
                        k = k + 1;
                    end
                end else begin
                    k = lb - 'ha1;
                    t = sb - 'ha1;
                end
                lead_q = 8'h00;
                base   = 4096 + (k * 94 + t) * 32;
                // Left half one glyph width back, then the right half.
                queue_glyph(cur - 8, 1'b1, base, 1'b0);
                queue_glyph(cur, 1'b1, base + 16, 1'b1);
            end
            // Every byte that gets this far moves the cursor, lead bytes too.
            cursor_q = cursor_q + t_cursor'(8);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Pop driver. It changes i_pop once per falling edge. A long hold-off
    // loaded into hold_left takes precedence over the short random bursts.
    initial begin : pop_driver
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap = rx_gap - 1;
                i_pop <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
                // Starts a stall burst of random length, this cycle included.
                rx_gap = $urandom_range(0, 5);
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Result check. A beat moves at a rising edge with i_pop high and o_empty
    // low; the values read here are the ones from before the edge.
    always @(posedge i_clk) begin : result_check
        t_glyph seen;
        t_glyph want;
        if (i_rst_n && i_pop && !o_empty) begin
            seen.draw_x      = o_draw_x;
            seen.font_select = o_font_select;
            seen.font_offset = o_font_offset;
            seen.last_result = o_last_result;
            if (glyph_q.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result beat with nothing expected: x=%h sel=%b off=%h last=%b",
                             $realtime, seen.draw_x, seen.font_select, seen.font_offset,
                             seen.last_result);
            end else begin
                want = glyph_q.pop_front();
                if (seen.draw_x !== want.draw_x || seen.font_select !== want.font_select ||
                    seen.font_offset !== want.font_offset ||
                    seen.last_result !== want.last_result) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch: expected x=%h sel=%b off=%h last=%b",
                                 $realtime, want.draw_x, want.font_select, want.font_offset,
                                 want.last_result);
                        $display("%0t: mismatch: got      x=%h sel=%b off=%h last=%b",
                                 $realtime, seen.draw_x, seen.font_select, seen.font_offset,
                                 seen.last_result);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Drives one input beat, starting at a falling edge, and returns at the
    // falling edge after the block took it. i_push is left high, so the next
    // beat can follow back to back; whoever comes next either drives a new
    // beat or lowers i_push at that same edge.
    task automatic send_byte(input logic [7:0] b, input logic ns, input logic [11:0] sx);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_push       <= 1'b1;
        i_code_byte  <= b;
        i_new_string <= ns;
        i_start_x    <= sx;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        predict_byte(b, ns, sx);
        @(negedge i_clk);
    endtask

    // Stops sending, waits for every expected beat and then lets the block
    // settle, since a lead byte or a dropped byte gives no beat to wait for.
    task automatic wait_idle();
        int waited;
        waited = 0;
        i_push <= 1'b0;
        while (glyph_q.size() != 0 && waited < IDLE_LIMIT) begin
            @(negedge i_clk);
            waited = waited + 1;
        end
        if (glyph_q.size() != 0) begin
            fail_count = fail_count + glyph_q.size();
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: %0d expected result beats never came", $realtime,
                         glyph_q.size());
            glyph_q.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the mode register. Called at a falling edge with the block idle.
    task automatic write_mode(input logic [1:0] m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        lang_mode_q = m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random stimulus helpers. Most strings do not start anew on every byte;
    // when they do, the start column is often at either end of the line.
    function automatic logic pick_new_string();
        return $urandom_range(0, 11) == 0;
    endfunction

    function automatic logic [11:0] pick_start_x();
        case ($urandom_range(0, 7))
            0:       return 12'h000;
            1:       return 12'hfff;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // Sends one random piece of text in the current mode: mostly a proper
    // double-byte character in the double-byte modes, otherwise a plain
    // character or a random byte. The random bytes break up sequences: a
    // stray lead, a zero byte, or a lead where a trail should be.
    task automatic send_text_unit(output int n_sent);
        int         r;
        logic [7:0] lead;
        logic [7:0] trail;
        r = $urandom_range(0, 15);
        if ((lang_mode_q == MODE_SJIS || lang_mode_q == MODE_EUC) && r < 10) begin
            if (lang_mode_q == MODE_SJIS) begin
                lead = $urandom_range(0, 1) ? 8'($urandom_range('h81, 'h9f))
                                            : 8'($urandom_range('he0, 'hfc));
                case ($urandom_range(0, 2))
                    0:       trail = 8'($urandom_range('h40, 'h7e));
                    1:       trail = 8'($urandom_range('h80, 'h9e));
                    default: trail = 8'($urandom_range('h9f, 'hfc));
                endcase
            end else if ($urandom_range(0, 7) == 0) begin
                // Lead below the row range: negative row.
                lead  = 8'($urandom_range('h81, 'ha0));
                trail = 8'($urandom_range(1, 255));
            end else begin
                lead  = 8'($urandom_range('ha1, 'hfe));
                trail = 8'($urandom_range('ha1, 'hfe));
            end
            send_byte(lead, pick_new_string(), pick_start_x());
            // Now and then a zero byte sits between lead and trail.
            if (r == 0)
                send_byte(8'h00, pick_new_string(), pick_start_x());
            send_byte(trail, pick_new_string(), pick_start_x());
            n_sent = (r == 0) ? 3 : 2;
        end else if (r < 13) begin
            send_byte(8'($urandom_range('h20, 'h7e)), pick_new_string(), pick_start_x());
            n_sent = 1;
        end else begin
            send_byte(8'($urandom_range(0, 255)), pick_new_string(), pick_start_x());
            n_sent = 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Built-in font: the byte extremes, a zero byte that only loads the
    // cursor, and the cursor wrap at the right edge.
    task automatic test_single_byte();
        write_mode(MODE_SINGLE);
        send_byte(8'h41, 1'b1, 12'h000);
        send_byte(8'hff, 1'b0, 12'hfff);
        send_byte(8'h00, 1'b1, 12'hfff);
        send_byte(8'h01, 1'b0, 12'h000);
        send_byte(8'h80, 1'b0, 12'h000);
    endtask

    // Shift-JIS: both lead ranges at their ends, every trail range, the
    // left half at a negative column, plain characters, a zero byte and a
    // new string while a lead is pending, and a malformed trail.
    task automatic test_sjis_pairs();
        wait_idle();
        write_mode(MODE_SJIS);
        send_byte(8'h81, 1'b1, 12'h000);
        send_byte(8'h40, 1'b0, 12'h000);
        send_byte(8'h9f, 1'b0, 12'h000);
        send_byte(8'h7e, 1'b0, 12'h000);
        send_byte(8'he0, 1'b0, 12'h000);
        send_byte(8'h80, 1'b0, 12'h000);
        send_byte(8'hfc, 1'b0, 12'h000);
        send_byte(8'h9e, 1'b0, 12'h000);
        send_byte(8'h81, 1'b0, 12'h000);
        send_byte(8'h9f, 1'b0, 12'h000);
        send_byte(8'ha0, 1'b0, 12'h000);
        send_byte(8'hfd, 1'b0, 12'h000);
        send_byte(8'h9f, 1'b0, 12'h000);
        send_byte(8'h00, 1'b0, 12'h000);
        send_byte(8'h01, 1'b1, 12'd100);
    endtask

    // EUC-JP: first and last row and cell, a lead below the row range with
    // a trail below the cell range, and a byte that is not a lead.
    task automatic test_euc_pairs();
        wait_idle();
        write_mode(MODE_EUC);
        send_byte(8'ha1, 1'b0, 12'h000);
        send_byte(8'ha1, 1'b0, 12'h000);
        send_byte(8'hfe, 1'b0, 12'h000);
        send_byte(8'hfe, 1'b0, 12'h000);
        send_byte(8'h81, 1'b0, 12'h000);
        send_byte(8'h20, 1'b0, 12'h000);
        send_byte(8'hff, 1'b0, 12'h000);
    endtask

    // A Shift-JIS lead stays pending through the off mode (where a new
    // string still loads the cursor) and through a single-byte glyph, and
    // is finally paired under EUC-JP rules.
    task automatic test_mode_switch();
        wait_idle();
        write_mode(MODE_SJIS);
        send_byte(8'he5, 1'b0, 12'h000);
        wait_idle();
        write_mode(MODE_OFF);
        send_byte(8'h41, 1'b1, 12'd2000);
        wait_idle();
        write_mode(MODE_SINGLE);
        send_byte(8'h42, 1'b0, 12'h000);
        wait_idle();
        write_mode(MODE_EUC);
        send_byte(8'h30, 1'b0, 12'h000);
    endtask

    // The bulk of the run: random text in phases, the mode changing between
    // them, with both sides idling at random.
    task automatic test_random_text();
        int         sent;
        int         n;
        int         quota;
        logic [1:0] m;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0, 3, 6, 9: m = MODE_SJIS;
                1, 5, 7:    m = MODE_EUC;
                2, 8:       m = MODE_SINGLE;
                default:    m = MODE_OFF;
            endcase
            quota = (m == MODE_OFF) ? 40 : 110;
            wait_idle();
            write_mode(m);
            sent = 0;
            while (sent < quota) begin
                send_text_unit(n);
                sent = sent + n;
            end
        end
    endtask

    // The result side holds off for a long stretch while beats keep coming,
    // so the queue inside the block fills and o_full stalls the input.
    task automatic test_back_pressure();
        int sent;
        int n;
        wait_idle();
        write_mode(MODE_SJIS);
        tx_idle_on = 1'b0;
        hold_left  = 200;
        sent = 0;
        while (sent < 60) begin
            send_text_unit(n);
            sent = sent + n;
        end
        tx_idle_on = 1'b1;
    endtask

    // Closing part at full rate on both sides, no idling at all.
    task automatic test_full_rate();
        int sent;
        int n;
        wait_idle();
        write_mode(MODE_EUC);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        sent = 0;
        while (sent < 80) begin
            send_text_unit(n);
            sent = sent + n;
        end
    endtask

    initial begin : main_seq
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_single_byte();
        test_sjis_pairs();
        test_euc_pairs();
        test_mode_switch();
        test_random_text();
        test_back_pressure();
        test_full_rate();
        wait_idle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // The slowest correct run is well under a millisecond of simulated time.
    initial begin : run_limit
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
